// ===== rtl/core/adaptive_huffman_encoder_assert.svh =====
// Assertion macros used by the checker.
`ifndef ADAPTIVE_HUFFMAN_ENCODER_ASSERT_SVH
`define ADAPTIVE_HUFFMAN_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AHE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define AHE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ahe_pkg.sv =====
package ahe_pkg;

  // Fixed field widths
  localparam int WEIGHT_W = 16;
  localparam int SYM_W    = 9;
  localparam int SYM_AW   = 9;

  // Defaults for the top level parameters
  localparam int NODE_COUNT_DEF = 515;
  localparam int MAX_WEIGHT_DEF = 32768;

  // Special symbols
  localparam int SYM_END   = 256;
  localparam int SYM_ESC   = 257;
  localparam int SYM_COUNT = 258;

  // Command codes
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_BYTE   = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  // Request from the stream side into the core
  typedef struct packed {
    logic        valid;
    logic [1:0]  command;
    logic [7:0]  symbol;
    logic [31:0] stream_length;
  } ahe_req_t;

  // Result from the core toward the output register
  typedef struct packed {
    logic        valid;
    logic [31:0] code_bits;
    logic [5:0]  code_length;
    logic        last;
  } ahe_res_t;

  typedef enum logic [5:0] {
    S_INIT0, S_INIT1, S_INIT2, S_IDLE, S_DROP, S_HDR,
    S_LOOKUP, S_CPOS, S_CODE, S_CODE_W, S_CRES, S_RAW,
    S_ADD0, S_ADD1, S_ADD2, S_ADD3,
    S_UPD, S_UPD_W, S_UPOS, S_UPOS_W, S_INC, S_INC_W, S_SRCH, S_SRCH_W,
    S_SWAPCHK, S_FIXA0, S_FIXA1, S_FIXB0, S_FIXB1, S_SWP0, S_SWP1,
    S_NEXT, S_NEXT_W,
    S_RS_BEGIN, S_RS1, S_RS1_W, S_RS2_BEGIN, S_RS2, S_RS2_A, S_RS2_B,
    S_RS2_K, S_RS2_KW, S_RS2_PUT, S_RS3_BEGIN, S_RS3, S_RS3_W, S_RS3_X, S_RS_END
  } ahe_state_t;

endpackage

// ===== rtl/core/adaptive_huffman_encoder.sv =====
// Adaptive Huffman (FGK) byte encoder with escape and end-of-stream codes.
// Send command 0 (start) to emit the 32-bit length header and rebuild the
// tree, command 1 per byte, command 2 to emit the end code; command 3 is
// dropped. One transaction is taken at a time. A start emits the header and
// rewrites the starting tree; a finish walks the end code from leaf to root;
// a byte walks its code, then at each tree level increments a weight, scans
// for a swap partner and swaps two nodes when needed, all paced by the
// single read and write port of the node table. A rescale, when the root
// weight reaches MAX_WEIGHT, adds three passes over the used nodes, the
// insertion pass also shifting nodes. After reset the starting tree is written.
// The output register lets the next transaction in while a result waits.
module adaptive_huffman_encoder #(
  parameter int NODE_COUNT = ahe_pkg::NODE_COUNT_DEF,
  parameter int MAX_WEIGHT = ahe_pkg::MAX_WEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // symbol[7:0], stream_length[39:8]
  input  logic [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // code_bits[31:0], code_length[37:32], zero[39:38]
  output logic        m_tlast    // last
);

  import ahe_pkg::*;

  ahe_req_t req;
  ahe_res_t res;
  logic     idle;
  logic     res_ready;

  assign s_tready  = idle;
  assign req       = '{valid: s_tvalid && idle, command: s_tuser,
                       symbol: s_tdata[7:0], stream_length: s_tdata[39:8]};
  assign res_ready = !m_tvalid || m_tready;

  ahe_core #(.NODE_COUNT(NODE_COUNT), .MAX_WEIGHT(MAX_WEIGHT)) u_core (
    .clk, .rst, .req, .idle, .res, .res_ready
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      m_tdata <= {2'b00, res.code_length, res.code_bits};
      m_tlast <= res.last;
    end
  end

endmodule

// ===== rtl/core/ahe_ram.sv =====
module ahe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ahe_core.sv =====
module ahe_core #(
  parameter int NODE_COUNT = ahe_pkg::NODE_COUNT_DEF,
  parameter int MAX_WEIGHT = ahe_pkg::MAX_WEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  ahe_pkg::ahe_req_t req,
  output logic             idle,
  output ahe_pkg::ahe_res_t res,
  input  logic             res_ready
);

  import ahe_pkg::*;

  localparam int NAW   = $clog2(NODE_COUNT);
  localparam int IDX_W = (NAW > SYM_W) ? NAW : SYM_W;
  localparam int NW    = WEIGHT_W + IDX_W + 1;

  ahe_state_t state, state_next;

  // Captured request
  logic [1:0]  cmd_r;
  logic [7:0]  sym_r;
  logic [31:0] len_r;
  logic        esc;

  // Tree bookkeeping
  logic [IDX_W-1:0]    nf;
  logic [SYM_COUNT-1:0] known;
  logic [IDX_W-1:0]    cur, dst, n, top;
  logic [IDX_W:0]      i, j, k;
  logic [WEIGHT_W-1:0] w;
  logic [IDX_W-1:0]    a_child;
  logic                a_leaf;
  logic [NW-1:0]       b;
  logic [31:0]         code;
  logic [5:0]          size;

  // Memory ports
  logic             node_we, par_we, pos_we;
  logic [NAW-1:0]   node_waddr, node_raddr, par_waddr, par_raddr;
  logic [NW-1:0]    node_wdata, node_rdata;
  logic [IDX_W-1:0] par_wdata, par_rdata, pos_wdata, pos_rdata;
  logic [SYM_AW-1:0] pos_waddr, pos_raddr;

  logic [WEIGHT_W-1:0] rd_weight;
  logic [IDX_W-1:0]    rd_child;
  logic                rd_leaf;
  logic [WEIGHT_W:0]   half_sum;
  logic                full;

  assign rd_weight = node_rdata[NW-1 -: WEIGHT_W];
  assign rd_child  = node_rdata[IDX_W:1];
  assign rd_leaf   = node_rdata[0];
  assign half_sum  = ({1'b0, rd_weight} + 1'b1) >> 1;
  assign full      = (({1'b0, nf} + (IDX_W+1)'(2)) > (IDX_W+1)'(NODE_COUNT));

  ahe_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_node_ram (
    .clk, .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rdata)
  );

  ahe_ram #(.WIDTH(IDX_W), .DEPTH(NODE_COUNT)) u_par_ram (
    .clk, .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .raddr(par_raddr), .rdata(par_rdata)
  );

  ahe_ram #(.WIDTH(IDX_W), .DEPTH(SYM_COUNT)) u_pos_ram (
    .clk, .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT0;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory controls and result
  always_comb begin
    state_next = state;
    idle       = 1'b0;
    res        = '0;
    node_we    = 1'b0;
    node_waddr = '0;
    node_wdata = '0;
    node_raddr = '0;
    par_we     = 1'b0;
    par_waddr  = '0;
    par_wdata  = '0;
    par_raddr  = '0;
    pos_we     = 1'b0;
    pos_waddr  = '0;
    pos_wdata  = '0;
    pos_raddr  = '0;
    case (state)
      // Starting tree: root, end leaf, escape leaf
      S_INIT0: begin
        node_we    = 1'b1;
        node_waddr = NAW'(0);
        node_wdata = {WEIGHT_W'(2), IDX_W'(1), 1'b0};
        par_we     = 1'b1;
        par_waddr  = NAW'(0);
        pos_we     = 1'b1;
        pos_waddr  = SYM_AW'(SYM_END);
        pos_wdata  = IDX_W'(1);
        state_next = S_INIT1;
      end
      S_INIT1: begin
        node_we    = 1'b1;
        node_waddr = NAW'(1);
        node_wdata = {WEIGHT_W'(1), IDX_W'(SYM_END), 1'b1};
        par_we     = 1'b1;
        par_waddr  = NAW'(1);
        pos_we     = 1'b1;
        pos_waddr  = SYM_AW'(SYM_ESC);
        pos_wdata  = IDX_W'(2);
        state_next = S_INIT2;
      end
      S_INIT2: begin
        node_we    = 1'b1;
        node_waddr = NAW'(2);
        node_wdata = {WEIGHT_W'(1), IDX_W'(SYM_ESC), 1'b1};
        par_we     = 1'b1;
        par_waddr  = NAW'(2);
        state_next = S_IDLE;
      end
      S_IDLE: begin
        idle = 1'b1;
        if (req.valid) begin
          case (req.command)
            CMD_START:  state_next = S_HDR;
            CMD_BYTE:   state_next = S_LOOKUP;
            CMD_FINISH: state_next = S_LOOKUP;
            default:    state_next = S_DROP;
          endcase
        end
      end
      S_DROP: state_next = S_IDLE;
      S_HDR: begin
        res = '{valid: 1'b1, code_bits: len_r, code_length: 6'd32, last: 1'b1};
        if (res_ready) state_next = S_INIT0;
      end
      // Leaf-to-root code walk
      S_LOOKUP: begin
        if (cmd_r == CMD_FINISH) begin
          pos_raddr = SYM_AW'(SYM_END);
        end else if (esc) begin
          pos_raddr = SYM_AW'(SYM_ESC);
        end else begin
          pos_raddr = SYM_AW'(sym_r);
        end
        state_next = S_CPOS;
      end
      S_CPOS: state_next = S_CODE;
      S_CODE: begin
        par_raddr = n[NAW-1:0];
        if (n == '0) state_next = S_CRES;
        else         state_next = S_CODE_W;
      end
      S_CODE_W: state_next = S_CODE;
      S_CRES: begin
        res.valid     = 1'b1;
        res.code_bits = code;
        if (size == 6'd0)       res.code_length = 6'd1;
        else if (size > 6'd32)  res.code_length = 6'd32;
        else                    res.code_length = size;
        res.last = !esc;
        if (res_ready) begin
          if (cmd_r == CMD_FINISH) state_next = S_IDLE;
          else if (esc)            state_next = S_RAW;
          else                     state_next = S_UPD;
        end
      end
      S_RAW: begin
        res = '{valid: 1'b1, code_bits: {24'd0, sym_r}, code_length: 6'd8, last: 1'b1};
        if (res_ready) state_next = full ? S_IDLE : S_ADD0;
      end
      // Split the lightest leaf
      S_ADD0: begin
        node_raddr = NAW'(nf - 1'b1);
        state_next = S_ADD1;
      end
      S_ADD1: begin
        node_we    = 1'b1;
        node_waddr = nf[NAW-1:0];
        node_wdata = node_rdata;
        par_we     = 1'b1;
        par_waddr  = nf[NAW-1:0];
        par_wdata  = nf - 1'b1;
        pos_we     = 1'b1;
        pos_waddr  = rd_child[SYM_AW-1:0];
        pos_wdata  = nf;
        state_next = S_ADD2;
      end
      S_ADD2: begin
        node_we    = 1'b1;
        node_waddr = NAW'(nf - 1'b1);
        node_wdata = {b[NW-1 -: WEIGHT_W], nf, 1'b0};
        par_we     = 1'b1;
        par_waddr  = NAW'(nf + 1'b1);
        par_wdata  = nf - 1'b1;
        pos_we     = 1'b1;
        pos_waddr  = SYM_AW'(sym_r);
        pos_wdata  = nf + 1'b1;
        state_next = S_ADD3;
      end
      S_ADD3: begin
        node_we    = 1'b1;
        node_waddr = NAW'(nf + 1'b1);
        node_wdata = {WEIGHT_W'(0), IDX_W'(sym_r), 1'b1};
        state_next = S_UPD;
      end
      // Weight update, root first checked for rescale
      S_UPD: begin
        node_raddr = NAW'(0);
        state_next = S_UPD_W;
      end
      S_UPD_W: begin
        if (rd_weight >= WEIGHT_W'(MAX_WEIGHT)) state_next = S_RS_BEGIN;
        else                                    state_next = S_UPOS;
      end
      S_UPOS: begin
        pos_raddr  = SYM_AW'(sym_r);
        state_next = S_UPOS_W;
      end
      S_UPOS_W: state_next = S_INC;
      S_INC: begin
        node_raddr = cur[NAW-1:0];
        state_next = S_INC_W;
      end
      S_INC_W: begin
        node_we    = 1'b1;
        node_waddr = cur[NAW-1:0];
        node_wdata = {rd_weight + 1'b1, rd_child, rd_leaf};
        state_next = S_SRCH;
      end
      // Scan down for the first node at least as heavy
      S_SRCH: begin
        node_raddr = NAW'(dst - 1'b1);
        if (dst == '0) state_next = S_SWAPCHK;
        else           state_next = S_SRCH_W;
      end
      S_SRCH_W: begin
        if (rd_weight >= w) state_next = S_SWAPCHK;
        else                state_next = S_SRCH;
      end
      S_SWAPCHK: state_next = (dst == cur) ? S_NEXT : S_FIXA0;
      S_FIXA0: begin
        if (a_leaf) begin
          pos_we     = 1'b1;
          pos_waddr  = a_child[SYM_AW-1:0];
          pos_wdata  = dst;
          state_next = S_FIXB0;
        end else begin
          par_we     = 1'b1;
          par_waddr  = a_child[NAW-1:0];
          par_wdata  = dst;
          state_next = S_FIXA1;
        end
      end
      S_FIXA1: begin
        par_we     = 1'b1;
        par_waddr  = NAW'(a_child + 1'b1);
        par_wdata  = dst;
        state_next = S_FIXB0;
      end
      S_FIXB0: begin
        if (b[0]) begin
          pos_we     = 1'b1;
          pos_waddr  = b[SYM_AW:1];
          pos_wdata  = cur;
          state_next = S_SWP0;
        end else begin
          par_we     = 1'b1;
          par_waddr  = b[NAW:1];
          par_wdata  = cur;
          state_next = S_FIXB1;
        end
      end
      S_FIXB1: begin
        par_we     = 1'b1;
        par_waddr  = NAW'(b[IDX_W:1] + 1'b1);
        par_wdata  = cur;
        state_next = S_SWP0;
      end
      S_SWP0: begin
        node_we    = 1'b1;
        node_waddr = cur[NAW-1:0];
        node_wdata = b;
        state_next = S_SWP1;
      end
      S_SWP1: begin
        node_we    = 1'b1;
        node_waddr = dst[NAW-1:0];
        node_wdata = {w, a_child, a_leaf};
        state_next = S_NEXT;
      end
      S_NEXT: begin
        par_raddr = cur[NAW-1:0];
        if (cur == '0) state_next = S_IDLE;
        else           state_next = S_NEXT_W;
      end
      S_NEXT_W: state_next = S_INC;
      // Rescale, pass one: leaves packed to the top, weights halved
      S_RS_BEGIN: state_next = S_RS1;
      S_RS1: begin
        node_raddr = i[NAW-1:0];
        if (i[IDX_W]) state_next = S_RS2_BEGIN;
        else          state_next = S_RS1_W;
      end
      S_RS1_W: begin
        if (rd_leaf) begin
          node_we    = 1'b1;
          node_waddr = j[NAW-1:0];
          node_wdata = {half_sum[WEIGHT_W-1:0], rd_child, 1'b1};
        end
        state_next = S_RS1;
      end
      // Pass two: inner nodes rebuilt bottom up, inserted in order
      S_RS2_BEGIN: state_next = S_RS2;
      S_RS2: begin
        node_raddr = i[NAW-1:0];
        if (i[IDX_W] || j[IDX_W]) state_next = S_RS3_BEGIN;
        else                      state_next = S_RS2_A;
      end
      S_RS2_A: begin
        node_raddr = NAW'(i + 1'b1);
        state_next = S_RS2_B;
      end
      S_RS2_B: state_next = S_RS2_K;
      S_RS2_K: begin
        node_raddr = k[NAW-1:0];
        if (k > {1'b0, top}) state_next = S_RS2_PUT;
        else                 state_next = S_RS2_KW;
      end
      S_RS2_KW: begin
        if (w < rd_weight) begin
          node_we    = 1'b1;
          node_waddr = NAW'(k - 1'b1);
          node_wdata = node_rdata;
          state_next = S_RS2_K;
        end else begin
          state_next = S_RS2_PUT;
        end
      end
      S_RS2_PUT: begin
        node_we    = 1'b1;
        node_waddr = NAW'(k - 1'b1);
        node_wdata = {w, i[IDX_W-1:0], 1'b0};
        state_next = S_RS2;
      end
      // Pass three: parent and leaf links rebuilt
      S_RS3_BEGIN: state_next = S_RS3;
      S_RS3: begin
        node_raddr = i[NAW-1:0];
        if (i[IDX_W]) state_next = S_RS_END;
        else          state_next = S_RS3_W;
      end
      S_RS3_W: begin
        if (rd_leaf) begin
          pos_we     = 1'b1;
          pos_waddr  = rd_child[SYM_AW-1:0];
          pos_wdata  = i[IDX_W-1:0];
          state_next = S_RS3;
        end else begin
          par_we     = 1'b1;
          par_waddr  = rd_child[NAW-1:0];
          par_wdata  = i[IDX_W-1:0];
          state_next = S_RS3_X;
        end
      end
      S_RS3_X: begin
        par_we     = 1'b1;
        par_waddr  = NAW'(a_child + 1'b1);
        par_wdata  = i[IDX_W-1:0];
        state_next = S_RS3;
      end
      S_RS_END: begin
        par_we     = 1'b1;
        par_waddr  = NAW'(0);
        state_next = S_UPOS;
      end
      default: state_next = S_INIT0;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_INIT0: begin
        // Only the end and escape leaves are known at start
        known <= (SYM_COUNT'(1) << SYM_END) | (SYM_COUNT'(1) << SYM_ESC);
        nf    <= IDX_W'(3);
      end
      S_IDLE: begin
        cmd_r <= req.command;
        sym_r <= req.symbol;
        len_r <= req.stream_length;
        esc   <= (req.command == CMD_BYTE) && !known[req.symbol];
      end
      S_CPOS: begin
        n    <= pos_rdata;
        code <= '0;
        size <= '0;
      end
      S_CODE: begin
        if (n != '0) begin
          if (!n[0] && size < 6'd32) code[size[4:0]] <= 1'b1;
          if (size < 6'd33) size <= size + 1'b1;
        end
      end
      S_CODE_W: n <= par_rdata;
      S_ADD1:   b <= node_rdata;
      S_ADD2:   known[sym_r] <= 1'b1;
      S_ADD3:   nf <= nf + IDX_W'(2);
      S_UPOS_W: cur <= pos_rdata;
      S_INC_W: begin
        w       <= rd_weight + 1'b1;
        a_child <= rd_child;
        a_leaf  <= rd_leaf;
        dst     <= cur;
      end
      S_SRCH_W: begin
        if (rd_weight < w) begin
          dst <= dst - 1'b1;
          b   <= node_rdata;
        end
      end
      S_SWP1:   cur <= dst;
      S_NEXT_W: cur <= par_rdata;
      S_RS_BEGIN: begin
        top <= nf - 1'b1;
        i   <= {1'b0, nf - 1'b1};
        j   <= {1'b0, nf - 1'b1};
      end
      S_RS1_W: begin
        if (rd_leaf) j <= j - 1'b1;
        i <= i - 1'b1;
      end
      S_RS2_BEGIN: i <= {1'b0, top} - 1'b1;
      S_RS2_A:     w <= rd_weight;
      S_RS2_B: begin
        w <= w + rd_weight;
        k <= j + 1'b1;
      end
      S_RS2_KW: begin
        if (w < rd_weight) k <= k + 1'b1;
      end
      S_RS2_PUT: begin
        i <= i - (IDX_W+1)'(2);
        j <= j - 1'b1;
      end
      S_RS3_BEGIN: i <= {1'b0, top};
      S_RS3_W: begin
        a_child <= rd_child;
        if (rd_leaf) i <= i - 1'b1;
      end
      S_RS3_X: i <= i - 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/ahe_checker.sv =====
module ahe_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [39:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);

`include "adaptive_huffman_encoder_assert.svh"

  // A stalled result holds
  `AHE_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

  // Code length is 1..32 and the pad bits are zero
  `AHE_ASSERT_NOW(a_len, m_tvalid, m_tdata[37:32] != 6'd0 && m_tdata[37:32] <= 6'd32 && m_tdata[39:38] == 2'd0, "bad code length")

  // The core works one transaction at a time
  `AHE_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready, "ready right after a transaction")

  // An escape code is always followed by its raw bits before new input
  `AHE_ASSERT_NOW(a_esc, m_tvalid && !m_tlast, !s_tready, "input taken between escape code and raw bits")

endmodule

bind adaptive_huffman_encoder ahe_checker u_ahe_checker (.*);
